@@ sv/ale_pkg.sv @@
// shared constants and types for the array list engine
package ale_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W = 7;
  localparam int VAL_W = 32;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_LOCATE = 3'd2,
    ACT_SORT   = 3'd3,
    ACT_DEDUPE = 3'd4,
    ACT_CLEAR  = 3'd5,
    ACT_READ   = 3'd6
  } act_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

@@ sv/array_list_engine.sv @@
// array list engine: bounded ordered list of signed words in one single-port memory
//
// The list lives in one synchronous single-port memory of DEPTH 32-bit words plus a
// length register; every action walks that memory one access per cycle, and the
// port is what sets the pace. One beat is taken at a time: in_ready is high only
// while no action is in progress, and the result beat sits in an output register,
// so the next beat may be taken while an earlier result still waits for out_ready.
// Clear, rejected actions and action code 7 go straight to the result; read waits
// for the memory data; insert and delete shift the tail one entry at a time; locate
// probes entries in turn until a match or the end; sort and dedupe make nested passes
// over the list. Sort is an exchange sort with the running minimum held in a register
// and written back once per pass. Dedupe compacts in place: each entry is compared
// against the kept prefix and appended when new, which leaves first occurrences in
// their original order. Entries at or above the length are never read, so the
// memory needs no clearing.
module array_list_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_action,
  input  logic [ale_pkg::LEN_W-1:0]         in_position,
  input  logic signed [ale_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [ale_pkg::LEN_W-1:0]         out_found_position,
  output logic signed [ale_pkg::VAL_W-1:0]  out_element,
  output logic [ale_pkg::LEN_W-1:0]         out_length
);
  import ale_pkg::*;

  // one-hot sequencer states
  typedef enum logic [16:0] {
    S_IDLE    = 17'b00000000000000001,
    S_INS_RD  = 17'b00000000000000010,
    S_INS_WR  = 17'b00000000000000100,
    S_DEL_RD  = 17'b00000000000001000,
    S_DEL_WR  = 17'b00000000000010000,
    S_LOC_RD  = 17'b00000000000100000,
    S_LOC_CMP = 17'b00000000001000000,
    S_SRT_RA  = 17'b00000000010000000,
    S_SRT_LA  = 17'b00000000100000000,
    S_SRT_RB  = 17'b00000001000000000,
    S_SRT_CB  = 17'b00000010000000000,
    S_DUP_RV  = 17'b00000100000000000,
    S_DUP_LV  = 17'b00001000000000000,
    S_DUP_RK  = 17'b00010000000000000,
    S_DUP_CK  = 17'b00100000000000000,
    S_RD_WAIT = 17'b01000000000000000,
    S_DONE    = 17'b10000000000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   pos_r, pos_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [LEN_W-1:0]   idx_a_r, idx_a_nxt;   // outer index / shift pointer / read pointer
  logic [LEN_W-1:0]   idx_b_r, idx_b_nxt;   // inner index
  logic [LEN_W-1:0]   idx_w_r, idx_w_nxt;   // dedupe write pointer
  logic [VAL_W-1:0]   hold_r, hold_nxt;     // running minimum / candidate word
  status_t            res_status_r, res_status_nxt;
  logic [LEN_W-1:0]   res_found_r, res_found_nxt;
  logic [VAL_W-1:0]   res_elem_r, res_elem_nxt;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [LEN_W-1:0]   out_found_r;
  logic [VAL_W-1:0]   out_elem_r;
  logic [LEN_W-1:0]   out_len_r;

  // element memory, read-first, registered read data
  logic [VAL_W-1:0]   elem_mem_r [DEPTH];
  logic [VAL_W-1:0]   mem_rdata_r;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [VAL_W-1:0]   mem_wd;

  logic [LEN_W-1:0]   in_pos_dec;
  logic [LEN_W-1:0]   pos_dec;
  logic [LEN_W-1:0]   idx_a_dec;
  logic [LEN_W-1:0]   idx_a_inc;
  logic [LEN_W-1:0]   idx_b_inc;
  logic [LEN_W-1:0]   idx_w_inc;
  logic [LEN_W-1:0]   len_inc;
  logic               load_out;

  assign in_pos_dec = in_position - LEN_W'(1);
  assign pos_dec    = pos_r - LEN_W'(1);
  assign idx_a_dec  = idx_a_r - LEN_W'(1);
  assign idx_a_inc  = idx_a_r + LEN_W'(1);
  assign idx_b_inc  = idx_b_r + LEN_W'(1);
  assign idx_w_inc  = idx_w_r + LEN_W'(1);
  assign len_inc    = len_r + LEN_W'(1);

  // result register frees up when empty or being taken this cycle
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_element        = out_elem_r;
  assign out_length         = out_len_r;

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    idx_a_nxt      = idx_a_r;
    idx_b_nxt      = idx_b_r;
    idx_w_nxt      = idx_w_r;
    hold_nxt       = hold_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_elem_nxt   = res_elem_r;
    mem_we         = 1'b0;
    mem_addr       = idx_a_r[AW-1:0];
    mem_wd         = hold_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt        = in_position;
          val_nxt        = in_value;
          res_status_nxt = ST_OK;
          res_found_nxt  = '0;
          res_elem_nxt   = '0;
          state_nxt      = S_DONE;
          case (act_t'(in_action))
            ACT_INSERT: begin
              // full check wins over the position check
              if (len_r == LEN_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else if (in_position == '0 || in_position > len_inc) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                idx_a_nxt = len_r;
                state_nxt = S_INS_RD;
              end
            end
            ACT_DELETE: begin
              if (in_position == '0 || in_position > len_r) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                idx_a_nxt = in_pos_dec;
                state_nxt = S_DEL_RD;
              end
            end
            ACT_LOCATE: begin
              idx_a_nxt = '0;
              state_nxt = S_LOC_RD;
            end
            ACT_SORT: begin
              idx_a_nxt = '0;
              state_nxt = S_SRT_RA;
            end
            ACT_DEDUPE: begin
              idx_a_nxt = '0;
              idx_w_nxt = '0;
              state_nxt = S_DUP_RV;
            end
            ACT_CLEAR: begin
              len_nxt = '0;
            end
            ACT_READ: begin
              if (in_position == '0 || in_position > len_r) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                mem_addr  = in_pos_dec[AW-1:0];
                state_nxt = S_RD_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // shift the tail up, starting from the old end
      S_INS_RD: begin
        if (idx_a_r >= pos_r) begin
          mem_addr  = idx_a_dec[AW-1:0];
          state_nxt = S_INS_WR;
        end else begin
          mem_we    = 1'b1;
          mem_addr  = pos_dec[AW-1:0];
          mem_wd    = val_r;
          len_nxt   = len_inc;
          state_nxt = S_DONE;
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_addr  = idx_a_r[AW-1:0];
        mem_wd    = mem_rdata_r;
        idx_a_nxt = idx_a_dec;
        state_nxt = S_INS_RD;
      end

      // shift the tail down over the removed entry
      S_DEL_RD: begin
        if (idx_a_inc < len_r) begin
          mem_addr  = idx_a_inc[AW-1:0];
          state_nxt = S_DEL_WR;
        end else begin
          len_nxt   = len_r - LEN_W'(1);
          state_nxt = S_DONE;
        end
      end
      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_addr  = idx_a_r[AW-1:0];
        mem_wd    = mem_rdata_r;
        idx_a_nxt = idx_a_inc;
        state_nxt = S_DEL_RD;
      end

      S_LOC_RD: begin
        if (idx_a_r < len_r) begin
          mem_addr  = idx_a_r[AW-1:0];
          state_nxt = S_LOC_CMP;
        end else begin
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_DONE;
        end
      end
      S_LOC_CMP: begin
        if (mem_rdata_r == val_r) begin
          res_found_nxt = idx_a_inc;
          state_nxt     = S_DONE;
        end else begin
          idx_a_nxt = idx_a_inc;
          state_nxt = S_LOC_RD;
        end
      end

      // exchange sort, entry a kept in hold_r during its pass
      S_SRT_RA: begin
        if (idx_a_r < len_r) begin
          mem_addr  = idx_a_r[AW-1:0];
          idx_b_nxt = idx_a_inc;
          state_nxt = S_SRT_LA;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SRT_LA: begin
        hold_nxt  = mem_rdata_r;
        state_nxt = S_SRT_RB;
      end
      S_SRT_RB: begin
        if (idx_b_r < len_r) begin
          mem_addr  = idx_b_r[AW-1:0];
          state_nxt = S_SRT_CB;
        end else begin
          mem_we    = 1'b1;
          mem_addr  = idx_a_r[AW-1:0];
          mem_wd    = hold_r;
          idx_a_nxt = idx_a_inc;
          state_nxt = S_SRT_RA;
        end
      end
      S_SRT_CB: begin
        if ($signed(hold_r) > $signed(mem_rdata_r)) begin
          mem_we   = 1'b1;
          mem_addr = idx_b_r[AW-1:0];
          mem_wd   = hold_r;
          hold_nxt = mem_rdata_r;
        end
        idx_b_nxt = idx_b_inc;
        state_nxt = S_SRT_RB;
      end

      // in-place compaction keeping first occurrences
      S_DUP_RV: begin
        if (idx_a_r < len_r) begin
          mem_addr  = idx_a_r[AW-1:0];
          state_nxt = S_DUP_LV;
        end else begin
          len_nxt   = idx_w_r;
          state_nxt = S_DONE;
        end
      end
      S_DUP_LV: begin
        hold_nxt  = mem_rdata_r;
        idx_b_nxt = '0;
        state_nxt = S_DUP_RK;
      end
      S_DUP_RK: begin
        if (idx_b_r < idx_w_r) begin
          mem_addr  = idx_b_r[AW-1:0];
          state_nxt = S_DUP_CK;
        end else begin
          mem_we    = 1'b1;
          mem_addr  = idx_w_r[AW-1:0];
          mem_wd    = hold_r;
          idx_w_nxt = idx_w_inc;
          idx_a_nxt = idx_a_inc;
          state_nxt = S_DUP_RV;
        end
      end
      S_DUP_CK: begin
        if (mem_rdata_r == hold_r) begin
          idx_a_nxt = idx_a_inc;
          state_nxt = S_DUP_RV;
        end else begin
          idx_b_nxt = idx_b_inc;
          state_nxt = S_DUP_RK;
        end
      end

      S_RD_WAIT: begin
        res_elem_nxt = mem_rdata_r;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      elem_mem_r[mem_addr] <= mem_wd;
    end
    mem_rdata_r <= elem_mem_r[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    idx_a_r      <= idx_a_nxt;
    idx_b_r      <= idx_b_nxt;
    idx_w_r      <= idx_w_nxt;
    hold_r       <= hold_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_elem_r   <= res_elem_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_elem_r   <= res_elem_r;
      out_len_r    <= len_r;
    end
  end

  // length never passes the capacity
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(DEPTH))
    else $error("list length beyond capacity");

  // the memory is written only while an action runs
  a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r != S_IDLE)
    else $error("memory write while idle");

  // a taken beat always starts an action
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != S_IDLE)
    else $error("accepted beat did not start an action");

  // a result beat appears only out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat without a finished action");

  // a full report comes only with a full list
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> out_len_r == LEN_W'(DEPTH))
    else $error("full status with a list that is not full");

endmodule

@@ test/array_list_engine_test.sv @@
// self-checking testbench for the array list engine: directed table, then random beats
module array_list_engine_test;
  import ale_pkg::*;

  // action code 7 has no package name; the block must ignore it
  localparam logic [2:0] ACT_SPARE = 3'd7;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  // one result beat as the block should produce it, plus the action for reports
  typedef struct {
    logic [2:0]         act;
    status_t            status;
    logic [6:0]         found;
    logic signed [31:0] elem;
    logic [6:0]         len;
  } list_result_t;

  // one row of the directed table; when typed is set the result is written out by hand
  typedef struct {
    logic [2:0]         act;
    logic [6:0]         pos;
    logic signed [31:0] val;
    bit                 typed;
    list_result_t       want;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_action;
  logic [6:0]         in_position;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic [6:0]         out_found_position;
  logic signed [31:0] out_element;
  logic [6:0]         out_length;

  // shadow copy of the list kept by the predictor
  logic signed [31:0] shadow_list [DEPTH];
  int                 shadow_len;

  list_result_t       expected_results [$];
  stim_row_t          directed_rows [$];
  int                 mismatch_count;
  int                 ready_hold;
  bit                 in_idle_on;
  bit                 out_stall_on;

  array_list_engine i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_element        (out_element),
    .out_length         (out_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs; well above the slowest legal run
  initial begin
    #40000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // predictor: apply one action to the shadow list and work out its result beat
  function automatic list_result_t apply_list_action(input logic [2:0] act,
                                                     input logic [6:0] pos,
                                                     input logic signed [31:0] val);
    list_result_t       r;
    int                 p;
    int                 i;
    int                 j;
    int                 kept;
    bit                 seen;
    logic signed [31:0] tmp;
    r.act    = act;
    r.status = ST_OK;
    r.found  = '0;
    r.elem   = '0;
    p        = int'(pos);
    case (act)
      ACT_INSERT: begin
        // a full list wins over a bad position
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > shadow_len + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = shadow_len; i >= p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p-1] = val;
          shadow_len++;
        end
      end
      ACT_DELETE: begin
        if (p < 1 || p > shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = p - 1; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      ACT_LOCATE: begin
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] == val && r.found == 0) r.found = 7'(i + 1);
        end
        if (r.found == 0) r.status = ST_NOTFOUND;
      end
      ACT_SORT: begin
        // plain insertion sort, signed ascending
        for (i = 1; i < shadow_len; i++) begin
          tmp = shadow_list[i];
          j   = i - 1;
          while (j >= 0 && shadow_list[j] > tmp) begin
            shadow_list[j+1] = shadow_list[j];
            j--;
          end
          shadow_list[j+1] = tmp;
        end
      end
      ACT_DEDUPE: begin
        // keep first occurrences, packed to the front in order
        kept = 0;
        for (i = 0; i < shadow_len; i++) begin
          seen = 1'b0;
          for (j = 0; j < kept; j++) begin
            if (shadow_list[j] == shadow_list[i]) seen = 1'b1;
          end
          if (!seen) begin
            shadow_list[kept] = shadow_list[i];
            kept++;
          end
        end
        shadow_len = kept;
      end
      ACT_CLEAR: begin
        shadow_len = 0;
      end
      ACT_READ: begin
        if (p < 1 || p > shadow_len) r.status = ST_BADPOS;
        else r.elem = shadow_list[p-1];
      end
      default: begin
      end
    endcase
    r.len = 7'(shadow_len);
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] act, input int pos,
                                  input logic signed [31:0] val, input bit typed,
                                  input status_t st = ST_OK, input int found = 0,
                                  input logic signed [31:0] elem = 0, input int len = 0);
    stim_row_t row;
    row.act         = act;
    row.pos         = 7'(pos);
    row.val         = val;
    row.typed       = typed;
    row.want.act    = act;
    row.want.status = st;
    row.want.found  = 7'(found);
    row.want.elem   = elem;
    row.want.len    = 7'(len);
    directed_rows.push_back(row);
  endfunction

  // drive one input beat, wait for it to be taken, then queue its expected result
  task automatic send_beat(input logic [2:0] act, input logic [6:0] pos,
                           input logic signed [31:0] val, input bit typed = 1'b0,
                           input list_result_t want = '{act: '0, status: ST_OK,
                                                        found: '0, elem: '0,
                                                        len: '0});
    int           gap;
    list_result_t pred;
    gap = in_idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (!in_ready);
    pred = apply_list_action(act, pos, val);
    expected_results.push_back(typed ? want : pred);
  endtask

  // value source: fully random, a small cluster, the extremes, or one already stored
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $signed(32'($urandom_range(0, 6))) - 32'sd3;
      2: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end
      default: v = (shadow_len > 0) ? shadow_list[$urandom_range(0, shadow_len - 1)]
                                    : $urandom;
    endcase
    return v;
  endfunction

  // position source: usually inside the list, sometimes anywhere in the 7-bit range
  function automatic logic [6:0] pick_position(input int top);
    if (top < 1 || $urandom_range(0, 4) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(1, top));
  endfunction

  task automatic random_beat();
    int          r;
    logic [2:0]  act;
    logic [6:0]  pos;
    r   = $urandom_range(0, 99);
    pos = '0;
    if (r < 43) begin
      act = ACT_INSERT;
      pos = pick_position(shadow_len + 1);
    end else if (r < 55) begin
      act = ACT_DELETE;
      pos = pick_position(shadow_len);
    end else if (r < 70) begin
      act = ACT_READ;
      pos = pick_position(shadow_len);
    end else if (r < 85) begin
      act = ACT_LOCATE;
      pos = 7'($urandom_range(0, 127));
    end else if (r < 90) begin
      act = ACT_SORT;
    end else if (r < 95) begin
      act = ACT_DEDUPE;
    end else if (r < 98) begin
      act = ACT_CLEAR;
    end else begin
      act = ACT_SPARE;
      pos = 7'($urandom_range(0, 127));
    end
    send_beat(act, pos, pick_value());
  endtask

  // compare a result beat against the oldest expectation
  always @(posedge clk) begin
    list_result_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      ready_hold <= out_stall_on ? $urandom_range(0, 5) : 0;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result beat with nothing expected: status %0d len %0d",
                   out_status, out_length);
      end else begin
        exp_beat = expected_results.pop_front();
        if (out_status !== exp_beat.status || out_found_position !== exp_beat.found ||
            out_element !== exp_beat.elem || out_length !== exp_beat.len) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("action %0d: expected st %0d found %0d elem %0d len %0d",
                     exp_beat.act, exp_beat.status, exp_beat.found, exp_beat.elem,
                     exp_beat.len);
            $display("  got st %0d found %0d elem %0d len %0d",
                     out_status, out_found_position, out_element, out_length);
          end
        end
      end
    end
  end

  // result side back-pressure: after each taken beat, hold ready low for a drawn count
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    int i;
    int n;
    // every input known from time zero
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = '0;
    in_position    = '0;
    in_value       = '0;
    out_ready      = 1'b0;
    ready_hold     = 0;
    mismatch_count = 0;
    shadow_len     = 0;
    in_idle_on     = 1'b1;
    out_stall_on   = 1'b1;

    // empty list behavior, bad positions, then a small list with both extremes
    add_row(ACT_READ,   1,   32'sd0, 1, ST_BADPOS,   0, 0, 0);
    add_row(ACT_DELETE, 1,   32'sd0, 1, ST_BADPOS,   0, 0, 0);
    add_row(ACT_LOCATE, 0,   32'sd5, 1, ST_NOTFOUND, 0, 0, 0);
    add_row(ACT_SORT,   0,   32'sd0, 1, ST_OK,       0, 0, 0);
    add_row(ACT_DEDUPE, 0,   32'sd0, 1, ST_OK,       0, 0, 0);
    add_row(ACT_INSERT, 0,   32'sd9, 1, ST_BADPOS,   0, 0, 0);
    add_row(ACT_INSERT, 2,   32'sd9, 1, ST_BADPOS,   0, 0, 0);
    add_row(ACT_INSERT, 1,   VAL_MAX, 1, ST_OK,      0, 0, 1);
    add_row(ACT_INSERT, 1,   VAL_MIN, 1, ST_OK,      0, 0, 2);
    add_row(ACT_INSERT, 3,   32'sd0,  1, ST_OK,      0, 0, 3);
    add_row(ACT_INSERT, 2,   -32'sd1, 1, ST_OK,      0, 0, 4);
    add_row(ACT_READ,   127, 32'sd0,  1, ST_BADPOS,  0, 0, 4);
    add_row(ACT_READ,   1,   32'sd0,  1, ST_OK,      0, VAL_MIN, 4);
    add_row(ACT_INSERT, 3,   VAL_MAX, 1, ST_OK,      0, 0, 5);
    // list is now min, -1, max, max, 0
    add_row(ACT_LOCATE, 0,   VAL_MAX, 1, ST_OK,      3, 0, 5);
    add_row(ACT_LOCATE, 0,   32'sh12345678, 1, ST_NOTFOUND, 0, 0, 5);
    add_row(ACT_SPARE,  127, 32'sh5555aaaa, 1, ST_OK, 0, 0, 5);
    add_row(ACT_SORT,   0,   32'sd0,  1, ST_OK,      0, 0, 5);
    add_row(ACT_READ,   4,   32'sd0,  1, ST_OK,      0, VAL_MAX, 5);
    add_row(ACT_DEDUPE, 0,   32'sd0,  1, ST_OK,      0, 0, 4);
    add_row(ACT_DELETE, 4,   32'sd0,  1, ST_OK,      0, 0, 3);
    add_row(ACT_DELETE, 1,   32'sd0,  1, ST_OK,      0, 0, 2);
    add_row(ACT_READ,   2,   32'sd0,  1, ST_OK,      0, 0, 2);
    add_row(ACT_DELETE, 3,   32'sd0,  1, ST_BADPOS,  0, 0, 2);
    add_row(ACT_CLEAR,  0,   32'sd0,  1, ST_OK,      0, 0, 0);
    add_row(ACT_INSERT, 1,   32'sh5a5a5a5a, 0);
    add_row(ACT_LOCATE, 0,   32'sh5a5a5a5a, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      send_beat(directed_rows[k].act, directed_rows[k].pos, directed_rows[k].val,
                directed_rows[k].typed, directed_rows[k].want);

    // first random stretch, idling on both sides
    for (i = 0; i < 20; i++) random_beat();

    // fill to capacity with no input gaps, then push on the full list
    in_idle_on = 1'b0;
    while (shadow_len < DEPTH)
      send_beat(ACT_INSERT, pick_position(shadow_len + 1), pick_value());
    send_beat(ACT_INSERT, 7'd1, 32'sd1);
    send_beat(ACT_INSERT, 7'd127, 32'sd1);
    send_beat(ACT_READ, 7'(DEPTH), 32'sd0);
    send_beat(ACT_LOCATE, 7'd0, shadow_list[DEPTH-1]);
    send_beat(ACT_SORT, 7'd0, 32'sd0);
    send_beat(ACT_READ, 7'd1, 32'sd0);
    send_beat(ACT_DEDUPE, 7'd0, 32'sd0);
    send_beat(ACT_DELETE, 7'd1, 32'sd0);

    // remaining random beats, switching idling per stretch of ten
    n = 0;
    while (n < 20) begin
      if (n % 10 == 0) begin
        in_idle_on   = $urandom_range(0, 2) != 0;
        out_stall_on = $urandom_range(0, 2) != 0;
      end
      random_beat();
      n++;
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then keep the clock running so that any stray beat would show
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
